### hdl/dfs_pkg.sv
// Package with the request, response and stack types and the bit-search helpers of the walk engine.
`timescale 1ns / 1ps
`default_nettype none

package dfs_pkg;

  localparam int NODES = 64;
  localparam int NODE_W = $clog2(NODES);
  localparam int LEVEL_W = $clog2(NODES + 1);
  localparam int GRP_W = 8;
  localparam int GRP_N = NODES / GRP_W;
  localparam int GRP_SEL_W = $clog2(GRP_N);
  localparam int BIT_SEL_W = $clog2(GRP_W);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_NEXT  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    EV_ACK      = 3'd0,
    EV_TREE     = 3'd1,
    EV_VISITED  = 3'd2,
    EV_ROOT_END = 3'd3,
    EV_DONE     = 3'd4
  } kind_e;

  typedef struct packed {
    op_e               op;
    logic [NODE_W-1:0] edge_from;
    logic [NODE_W-1:0] edge_to;
  } dfs_req_t;

  typedef struct packed {
    kind_e              event_kind;
    logic [NODE_W-1:0]  from_node;
    logic [NODE_W-1:0]  to_node;
    logic [LEVEL_W-1:0] depth;
  } dfs_rsp_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [LEVEL_W-1:0] cursor;
  } stk_entry_t;

  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] idx;
  } find_t;

  // Lowest set bit, found in two levels: first the group, then the bit inside it.
  function automatic find_t first_set(input logic [NODES-1:0] vec);
    logic [GRP_N-1:0]     grp_any;
    logic [GRP_SEL_W-1:0] g;
    logic [GRP_W-1:0]     sub;
    logic [BIT_SEL_W-1:0] b;
    find_t                r;
    for (int i = 0; i < GRP_N; i++) begin
      grp_any[i] = |vec[i*GRP_W +: GRP_W];
    end
    g = '0;
    for (int i = GRP_N - 1; i >= 0; i--) begin
      if (grp_any[i]) begin
        g = GRP_SEL_W'(i);
      end
    end
    sub = vec[g*GRP_W +: GRP_W];
    b = '0;
    for (int i = GRP_W - 1; i >= 0; i--) begin
      if (sub[i]) begin
        b = BIT_SEL_W'(i);
      end
    end
    r.found = |grp_any;
    r.idx = {g, b};
    return r;
  endfunction

  // Bits below position n are set.
  function automatic logic [NODES-1:0] below_mask(input logic [LEVEL_W-1:0] n);
    return ~({NODES{1'b1}} << n);
  endfunction

  // Bits at or above position n are set.
  function automatic logic [NODES-1:0] from_mask(input logic [LEVEL_W-1:0] n);
    return {NODES{1'b1}} << n;
  endfunction

endpackage

`default_nettype wire

### hdl/dfs_edge_walk_engine_core.sv
// Top level of the depth-first edge walk engine with its adjacency and stack memories.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken when start is high and busy is low; its single response is registered
// onto rsp_o, flagged by done_o for exactly one cycle, and the receiver cannot stall it.
// Clear and unused requests are answered from idle, as is an out-of-range edge add; any
// other edge add reads and writes back one adjacency row. A walk request that finds the walk
// done is answered with a done event. Otherwise it examines stack frames, each by a frame
// read from the stack memory, a row read from the adjacency memory, the registered
// next-neighbor search, then the decision; a descent adds a push step after the response,
// a new root adds a step of its own, and a frame that is left without a report is popped
// before the next frame is examined.
// The graph is cleared at once through per-row valid bits, so there is no clearing pass.
module dfs_edge_walk_engine_core
  import dfs_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire dfs_req_t           req_i,
  output logic                    done_o,
  output dfs_rsp_t                rsp_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [LEVEL_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_LOOP,
    S_TOP,
    S_ROW,
    S_ACT,
    S_PUSH
  } state_e;

  state_e             state_q, state_d;
  logic [LEVEL_W-1:0] node_count_q, node_count_d;
  logic [NODES-1:0]   row_vld_q, row_vld_d;
  logic [NODES-1:0]   visited_q, visited_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic [LEVEL_W-1:0] root_q, root_d;
  logic               finished_q, finished_d;
  logic [NODE_W-1:0]  from_q, from_d;
  logic [NODE_W-1:0]  to_q, to_d;
  logic [NODE_W-1:0]  top_node_q, top_node_d;
  logic [LEVEL_W-1:0] top_cur_q, top_cur_d;
  logic               found_q, found_d;
  logic [NODE_W-1:0]  nb_q, nb_d;
  logic               nonempty_q, nonempty_d;
  logic               done_q, done_d;
  dfs_rsp_t           rsp_q, rsp_d;

  logic [NODES-1:0]   adj_mem [NODES];
  logic [NODES-1:0]   adj_rdata_q;
  logic               adj_rvld_q;
  logic [NODE_W-1:0]  adj_raddr;
  logic               adj_we;
  logic [NODE_W-1:0]  adj_waddr;
  logic [NODES-1:0]   adj_wdata;

  stk_entry_t         stk_mem [NODES];
  stk_entry_t         stk_rdata_q;
  logic [NODE_W-1:0]  stk_raddr;
  logic               stk_we;
  logic [NODE_W-1:0]  stk_waddr;
  stk_entry_t         stk_wdata;

  logic [LEVEL_W-1:0] eff_cnt;
  logic [NODES-1:0]   cnt_mask;
  logic [NODES-1:0]   row_eff;
  logic [LEVEL_W-1:0] level_m1;
  find_t              root_find;
  find_t              nb_find;

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_rdata_q <= adj_mem[adj_raddr];
    adj_rvld_q <= row_vld_q[adj_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata_q <= stk_mem[stk_raddr];
  end

  assign eff_cnt = (node_count_q > LEVEL_W'(NODES)) ? LEVEL_W'(NODES) : node_count_q;
  assign cnt_mask = below_mask(eff_cnt);
  assign row_eff = adj_rvld_q ? adj_rdata_q : '0;
  assign level_m1 = level_q - LEVEL_W'(1);
  assign stk_raddr = level_m1[NODE_W-1:0];
  assign adj_raddr = (state_q == S_TOP) ? stk_rdata_q.node : req_i.edge_from;
  assign root_find = first_set(~visited_q & from_mask(root_q) & cnt_mask);
  assign nb_find = first_set(row_eff & from_mask(top_cur_q) & cnt_mask);

  assign busy = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign done_o = done_q;
  assign rsp_o = rsp_q;

  always_comb begin
    state_d = state_q;
    node_count_d = node_count_q;
    row_vld_d = row_vld_q;
    visited_d = visited_q;
    level_d = level_q;
    root_d = root_q;
    finished_d = finished_q;
    from_d = from_q;
    to_d = to_q;
    top_node_d = top_node_q;
    top_cur_d = top_cur_q;
    found_d = found_q;
    nb_d = nb_q;
    nonempty_d = nonempty_q;
    done_d = 1'b0;
    rsp_d = rsp_q;
    adj_we = 1'b0;
    adj_waddr = from_q;
    adj_wdata = row_eff | (NODES'(1) << to_q);
    stk_we = 1'b0;
    stk_waddr = stk_raddr;
    stk_wdata = '{node: top_node_q, cursor: {1'b0, nb_q} + LEVEL_W'(1)};

    if (cfg_valid_i && cfg_ready_o) begin
      node_count_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          from_d = req_i.edge_from;
          to_d = req_i.edge_to;
          unique case (req_i.op)
            OP_CLEAR: begin
              row_vld_d = '0;
              visited_d = '0;
              level_d = '0;
              root_d = '0;
              finished_d = 1'b0;
              done_d = 1'b1;
              rsp_d = '0;
              rsp_d.event_kind = EV_ACK;
            end
            OP_ADD: begin
              if (({1'b0, req_i.edge_from} < eff_cnt) && ({1'b0, req_i.edge_to} < eff_cnt)) begin
                state_d = S_ADD;
              end else begin
                done_d = 1'b1;
                rsp_d = '0;
                rsp_d.event_kind = EV_ACK;
              end
            end
            OP_NEXT: begin
              state_d = S_LOOP;
            end
            OP_NOP: begin
              done_d = 1'b1;
              rsp_d = '0;
              rsp_d.event_kind = EV_ACK;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_ADD: begin
        adj_we = 1'b1;
        row_vld_d[from_q] = 1'b1;
        done_d = 1'b1;
        rsp_d = '0;
        rsp_d.event_kind = EV_ACK;
        state_d = S_IDLE;
      end
      S_LOOP: begin
        priority if (finished_q) begin
          done_d = 1'b1;
          rsp_d = '0;
          rsp_d.event_kind = EV_DONE;
          state_d = S_IDLE;
        end else if (level_q != '0) begin
          state_d = S_TOP;
        end else if (!root_find.found) begin
          finished_d = 1'b1;
          done_d = 1'b1;
          rsp_d = '0;
          rsp_d.event_kind = EV_DONE;
          state_d = S_IDLE;
        end else begin
          visited_d[root_find.idx] = 1'b1;
          stk_we = 1'b1;
          stk_waddr = '0;
          stk_wdata = '{node: root_find.idx, cursor: '0};
          level_d = LEVEL_W'(1);
          root_d = {1'b0, root_find.idx} + LEVEL_W'(1);
        end
      end
      S_TOP: begin
        top_node_d = stk_rdata_q.node;
        top_cur_d = stk_rdata_q.cursor;
        state_d = S_ROW;
      end
      S_ROW: begin
        found_d = nb_find.found;
        nb_d = nb_find.idx;
        nonempty_d = |(row_eff & cnt_mask);
        state_d = S_ACT;
      end
      S_ACT: begin
        if (found_q) begin
          stk_we = 1'b1;
          done_d = 1'b1;
          rsp_d.from_node = top_node_q;
          rsp_d.to_node = nb_q;
          rsp_d.depth = level_q;
          state_d = S_IDLE;
          if (!visited_q[nb_q]) begin
            visited_d[nb_q] = 1'b1;
            rsp_d.event_kind = EV_TREE;
            if (level_q < LEVEL_W'(NODES)) begin
              state_d = S_PUSH;
            end
          end else begin
            rsp_d.event_kind = EV_VISITED;
          end
        end else begin
          level_d = level_m1;
          if ((level_q == LEVEL_W'(1)) && nonempty_q) begin
            done_d = 1'b1;
            rsp_d = '0;
            rsp_d.event_kind = EV_ROOT_END;
            rsp_d.from_node = top_node_q;
            rsp_d.depth = LEVEL_W'(1);
            state_d = S_IDLE;
          end else begin
            state_d = S_LOOP;
          end
        end
      end
      S_PUSH: begin
        stk_we = 1'b1;
        stk_waddr = level_q[NODE_W-1:0];
        stk_wdata = '{node: nb_q, cursor: '0};
        level_d = level_q + LEVEL_W'(1);
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      node_count_q <= LEVEL_W'(NODES);
      row_vld_q <= '0;
      visited_q <= '0;
      level_q <= '0;
      root_q <= '0;
      finished_q <= 1'b0;
      from_q <= '0;
      to_q <= '0;
      top_node_q <= '0;
      top_cur_q <= '0;
      found_q <= 1'b0;
      nb_q <= '0;
      nonempty_q <= 1'b0;
      done_q <= 1'b0;
      rsp_q <= '0;
    end else begin
      state_q <= state_d;
      node_count_q <= node_count_d;
      row_vld_q <= row_vld_d;
      visited_q <= visited_d;
      level_q <= level_d;
      root_q <= root_d;
      finished_q <= finished_d;
      from_q <= from_d;
      to_q <= to_d;
      top_node_q <= top_node_d;
      top_cur_q <= top_cur_d;
      found_q <= found_d;
      nb_q <= nb_d;
      nonempty_q <= nonempty_d;
      done_q <= done_d;
      rsp_q <= rsp_d;
    end
  end

  // Every accepted request either keeps the engine busy or answers in the next cycle.
  a_req_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("request neither started nor answered");

  // A finished walk has no open stack frame.
  a_finished_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> (level_q == '0))
    else $error("walk finished with open frames");

  // The node reached by a tree edge is marked visited.
  a_tree_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.event_kind == EV_TREE)) |-> visited_q[rsp_o.to_node])
    else $error("tree edge to unmarked node");

  // The stack never grows past NODES entries.
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LEVEL_W'(NODES))
    else $error("stack level out of range");

endmodule

`default_nettype wire
